FILE: hdl/sbtl_pkg.sv
// ----------------------------------------------------------------------------
// sbtl_pkg
// Shared types and constants of the sorted binding table lookup: table
// geometry, status and command codes, and the structs that run along the
// chain of table cells.
// ----------------------------------------------------------------------------
package sbtl_pkg;

	// table geometry
	localparam int KINDS   = 5;
	localparam int ENTRIES = 32;

	// field widths fixed by the interface
	localparam int KIND_IN_W = 3;
	localparam int CODE_W    = 8;
	localparam int MODS_W    = 16;
	localparam int KEY_W     = CODE_W + MODS_W;
	localparam int CTX_W     = 16;
	localparam int HANDLER_W = 16;
	localparam int ARG_W     = 32;
	localparam int STATUS_W  = 2;

	// derived widths
	localparam int KIND_W = (KINDS > 1) ? $clog2(KINDS) : 1;
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_KIND  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// ignore mask after reset
	localparam logic [MODS_W-1:0] IGNORE_MASK_RESET = 16'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// one table entry; key is code over modifiers
	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [CTX_W-1:0]     ctx;
		logic [HANDLER_W-1:0] handler;
		logic [ARG_W-1:0]     arg;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CNT_W-1:0]  count;
		logic              ins_en;
		entry_t            req;
	} bcast_t;

	// insert shift path, cell to upper neighbor
	typedef struct packed {
		logic   gt;
		entry_t ent;
	} shift_t;

	// scan token and running result, cell to upper neighbor
	typedef struct packed {
		logic   tok;
		logic   hit;
		entry_t ent;
	} carry_t;

endpackage

FILE: hdl/sbtl_cell.sv
// ----------------------------------------------------------------------------
// sbtl_cell
// One slot position of every table. Holds the entry at this position for
// each kind, shifts up on insert and checks the passing scan token.
// ----------------------------------------------------------------------------
module sbtl_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [sbtl_pkg::IDX_W-1:0] idx,
	input  sbtl_pkg::bcast_t      bc,
	input  sbtl_pkg::shift_t      left_sh,
	input  sbtl_pkg::carry_t      left_cy,
	output sbtl_pkg::shift_t      right_sh,
	output sbtl_pkg::carry_t      right_cy
);
	import sbtl_pkg::*;

	entry_t mem_q [KINDS];
	entry_t cur;
	logic   occ;
	logic   at_end;
	logic   gt;
	logic   match;
	logic   tok_q;
	logic   hit_q;
	entry_t ent_q;

	// slot state for the selected table
	always_comb begin
		cur    = mem_q[bc.kind];
		occ    = CNT_W'(idx) < bc.count;
		at_end = CNT_W'(idx) == bc.count;
		gt     = occ && (cur.key > bc.req.key);
		match  = occ && (cur.key == bc.req.key) && (|(cur.ctx & bc.req.ctx));
	end

	assign right_sh.gt  = gt;
	assign right_sh.ent = cur;

	// insert: take the lower neighbor's entry or the new one
	always_ff @(posedge clk) begin
		if (bc.ins_en) begin
			if (left_sh.gt) begin
				mem_q[bc.kind] <= left_sh.ent;
			end else if (gt || at_end) begin
				mem_q[bc.kind] <= bc.req;
			end
		end
	end

	// scan token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= left_cy.tok;
		end
	end

	// first match along the chain wins
	always_ff @(posedge clk) begin
		if (left_cy.tok && !left_cy.hit && match) begin
			hit_q <= 1'b1;
			ent_q <= cur;
		end else begin
			hit_q <= left_cy.hit;
			ent_q <= left_cy.ent;
		end
	end

	assign right_cy.tok = tok_q;
	assign right_cy.hit = hit_q;
	assign right_cy.ent = ent_q;

endmodule

FILE: hdl/sbtl_ctrl.sv
// ----------------------------------------------------------------------------
// sbtl_ctrl
// Sequencer of the lookup block: takes items, keeps fill counts and the
// ignore mask, drives the cell chain and holds the result register.
// ----------------------------------------------------------------------------
module sbtl_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [sbtl_pkg::KIND_IN_W-1:0]   event_kind,
	input  logic [sbtl_pkg::CODE_W-1:0]      code,
	input  logic [sbtl_pkg::MODS_W-1:0]      modifiers,
	input  logic [sbtl_pkg::CTX_W-1:0]       context_mask,
	input  logic [sbtl_pkg::HANDLER_W-1:0]   handler_id,
	input  logic [sbtl_pkg::ARG_W-1:0]       handler_arg,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sbtl_pkg::MODS_W-1:0]      cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sbtl_pkg::STATUS_W-1:0]    status,
	output logic [sbtl_pkg::HANDLER_W-1:0]   found_handler,
	output logic [sbtl_pkg::ARG_W-1:0]       found_arg,
	output logic [sbtl_pkg::CTX_W-1:0]       found_context,
	output sbtl_pkg::bcast_t                 bc,
	output sbtl_pkg::carry_t                 head,
	input  sbtl_pkg::carry_t                 tail
);
	import sbtl_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    counts_q [KINDS];
	logic [MODS_W-1:0]   mask_q;
	logic [KIND_W-1:0]   kind_q;
	entry_t              req_q;
	logic                launch_q;
	logic [STATUS_W-1:0] res_status_q;
	entry_t              res_ent_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	entry_t              out_ent_q;

	logic                kind_ok;
	logic                full;
	logic                take;
	logic                ins_en;
	logic                retry;
	logic                scan_done;
	logic                out_load;
	logic [KIND_W-1:0]   kind_in;

	// request checks on the input payload
	always_comb begin
		kind_in = event_kind[KIND_W-1:0];
		kind_ok = {1'b0, event_kind} < (KIND_IN_W + 1)'(KINDS);
		full    = counts_q[kind_in] >= CNT_W'(ENTRIES);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		ins_en    = 1'b0;
		retry     = 1'b0;
		scan_done = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					take = 1'b1;
					if (!kind_ok) begin
						state_d = ST_FINISH;
					end else if (command == CMD_LOOKUP) begin
						state_d = ST_SCAN;
					end else if (full) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_INSERT;
					end
				end
			end
			ST_INSERT: begin
				ins_en  = 1'b1;
				state_d = ST_FINISH;
			end
			ST_SCAN: begin
				if (tail.tok) begin
					if (!tail.hit && (req_q.key[KEY_W-1:MODS_W] != '0)) begin
						retry = 1'b1;
					end else begin
						scan_done = 1'b1;
						state_d   = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// control registers: counts, mask, scan launch, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KINDS; k++) begin
				counts_q[k] <= '0;
			end
			mask_q      <= IGNORE_MASK_RESET;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_en) begin
				counts_q[kind_q] <= counts_q[kind_q] + 1'b1;
			end
			if (cfg_valid) begin
				mask_q <= cfg_data;
			end
			launch_q <= (take && kind_ok && (command == CMD_LOOKUP)) || retry;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q          <= kind_in;
			req_q.ctx       <= context_mask;
			req_q.handler   <= handler_id;
			req_q.arg       <= handler_arg;
			res_ent_q       <= '0;
			if (command == CMD_LOOKUP) begin
				req_q.key <= {code, modifiers & ~mask_q};
			end else begin
				req_q.key <= {code, modifiers};
			end
			if (!kind_ok) begin
				res_status_q <= (command == CMD_LOOKUP) ? STATUS_NOT_FOUND
				                                        : STATUS_BAD_KIND;
			end else if ((command == CMD_INSERT) && full) begin
				res_status_q <= STATUS_FULL;
			end else begin
				res_status_q <= STATUS_OK;
			end
		end
		// second pass uses the wildcard code
		if (retry) begin
			req_q.key[KEY_W-1:MODS_W] <= '0;
		end
		if (scan_done) begin
			if (tail.hit) begin
				res_status_q <= STATUS_OK;
				res_ent_q    <= tail.ent;
			end else begin
				res_status_q <= STATUS_NOT_FOUND;
				res_ent_q    <= '0;
			end
		end
		if (out_load) begin
			status_q  <= res_status_q;
			out_ent_q <= res_ent_q;
		end
	end

	// chain drive
	always_comb begin
		bc.kind   = kind_q;
		bc.count  = counts_q[kind_q];
		bc.ins_en = ins_en;
		bc.req    = req_q;
		head.tok  = launch_q;
		head.hit  = 1'b0;
		head.ent  = '0;
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found_handler = out_ent_q.handler;
	assign found_arg     = out_ent_q.arg;
	assign found_context = out_ent_q.ctx;

endmodule

FILE: hdl/sorted_binding_table_lookup.sv
// ----------------------------------------------------------------------------
// sorted_binding_table_lookup
// Sorted per-kind binding tables with insert and two-pass lookup, built as
// a chain of slot cells under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid/in_stall carries one command per transfer:
//   insert an entry into the table of event_kind, or look one up
// - output channel out_valid/out_stall returns one result per command
// - cfg_valid/cfg_ready writes ignore_mask; cfg_ready is always high and
//   writes are expected only while the block is idle
// - one command is worked on at a time; in_stall is high from the transfer
//   until the result has moved into the output register
// - insert: the whole chain shifts together in the insert state, which is
//   skipped for a bad kind or full table; the answer then goes to finish
// - lookup: a token walks the chain one cell per cycle; a miss with a
//   nonzero code makes a second wildcard pass, so the result waits on one
//   or two passes along the length of the cell chain
// - a stalled result holds in the output register; the next command can be
//   taken while it waits, and its own result waits in the sequencer
// - reset empties every table (fill counts to zero) and sets ignore_mask
//   to 2; table storage itself is not cleared
// ----------------------------------------------------------------------------
module sorted_binding_table_lookup (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [sbtl_pkg::KIND_IN_W-1:0]   event_kind,
	input  logic [sbtl_pkg::CODE_W-1:0]      code,
	input  logic [sbtl_pkg::MODS_W-1:0]      modifiers,
	input  logic [sbtl_pkg::CTX_W-1:0]       context_mask,
	input  logic [sbtl_pkg::HANDLER_W-1:0]   handler_id,
	input  logic [sbtl_pkg::ARG_W-1:0]       handler_arg,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sbtl_pkg::MODS_W-1:0]      cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sbtl_pkg::STATUS_W-1:0]    status,
	output logic [sbtl_pkg::HANDLER_W-1:0]   found_handler,
	output logic [sbtl_pkg::ARG_W-1:0]       found_arg,
	output logic [sbtl_pkg::CTX_W-1:0]       found_context
);
	import sbtl_pkg::*;

	bcast_t bc;
	carry_t head;
	carry_t tail;
	shift_t sh_w [ENTRIES];
	carry_t cy_w [ENTRIES];

	// sequencer
	sbtl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.event_kind    (event_kind),
		.code          (code),
		.modifiers     (modifiers),
		.context_mask  (context_mask),
		.handler_id    (handler_id),
		.handler_arg   (handler_arg),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_handler (found_handler),
		.found_arg     (found_arg),
		.found_context (found_context),
		.bc            (bc),
		.head          (head),
		.tail          (tail)
	);

	// chain of slot cells, lowest slot first
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_first
			sbtl_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (IDX_W'(i)),
				.bc       (bc),
				.left_sh  (shift_t'('0)),
				.left_cy  (head),
				.right_sh (sh_w[i]),
				.right_cy (cy_w[i])
			);
		end else begin : g_rest
			sbtl_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (IDX_W'(i)),
				.bc       (bc),
				.left_sh  (sh_w[i-1]),
				.left_cy  (cy_w[i-1]),
				.right_sh (sh_w[i]),
				.right_cy (cy_w[i])
			);
		end
	end

	assign tail = cy_w[ENTRIES-1];

endmodule

FILE: tb/sbtl_checker.sv
// ----------------------------------------------------------------------------
// sbtl_checker
// Watches the command, result and ignore-mask channels of the sorted binding
// table lookup. Keeps its own copy of the per-kind tables, works out the
// answer to every accepted command and compares each returned result with
// the oldest answer still owed.
// ----------------------------------------------------------------------------
module sbtl_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           command,
	input  logic [sbtl_pkg::KIND_IN_W-1:0] event_kind,
	input  logic [sbtl_pkg::CODE_W-1:0]    code,
	input  logic [sbtl_pkg::MODS_W-1:0]    modifiers,
	input  logic [sbtl_pkg::CTX_W-1:0]     context_mask,
	input  logic [sbtl_pkg::HANDLER_W-1:0] handler_id,
	input  logic [sbtl_pkg::ARG_W-1:0]     handler_arg,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sbtl_pkg::MODS_W-1:0]    cfg_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [sbtl_pkg::STATUS_W-1:0]  status,
	input  logic [sbtl_pkg::HANDLER_W-1:0] found_handler,
	input  logic [sbtl_pkg::ARG_W-1:0]     found_arg,
	input  logic [sbtl_pkg::CTX_W-1:0]     found_context,
	output int                             errors,
	output int                             answers_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbtl_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [HANDLER_W-1:0] handler;
		logic [ARG_W-1:0]     arg;
		logic [CTX_W-1:0]     ctx;
	} answer_t;

	// shadow copy of the binding tables
	logic [KEY_W-1:0]     bind_key     [KINDS][ENTRIES];
	logic [CTX_W-1:0]     bind_ctx     [KINDS][ENTRIES];
	logic [HANDLER_W-1:0] bind_handler [KINDS][ENTRIES];
	logic [ARG_W-1:0]     bind_arg     [KINDS][ENTRIES];
	int                   bind_fill    [KINDS];
	logic [MODS_W-1:0]    mask_copy;

	answer_t expected_answers[$];
	answer_t got_answer;
	answer_t want_answer;
	int      fail_tally;

	// first slot with this key whose contexts overlap, -1 if none
	function automatic int find_binding(int kind, logic [KEY_W-1:0] key,
		logic [CTX_W-1:0] ctx);
		for (int i = 0; i < bind_fill[kind]; i++) begin
			if (bind_key[kind][i] > key)
				return -1;
			if (bind_key[kind][i] == key && (bind_ctx[kind][i] & ctx) != '0)
				return i;
		end
		return -1;
	endfunction

	// update the tables for one command and queue the answer it owes
	task automatic resolve_command();
		answer_t           ans;
		int                kind;
		int                pos;
		int                hit;
		logic [KEY_W-1:0]  key;
		logic [MODS_W-1:0] live_mods;
		ans = '0;
		kind = int'(event_kind);
		if (command == CMD_INSERT) begin
			if (kind >= KINDS) begin
				ans.status = STATUS_BAD_KIND;
			end else if (bind_fill[kind] >= ENTRIES) begin
				ans.status = STATUS_FULL;
			end else begin
				key = {code, modifiers};
				pos = 0;
				while (pos < bind_fill[kind] && bind_key[kind][pos] <= key)
					pos++;
				for (int j = bind_fill[kind]; j > pos; j--) begin
					bind_key[kind][j]     = bind_key[kind][j-1];
					bind_ctx[kind][j]     = bind_ctx[kind][j-1];
					bind_handler[kind][j] = bind_handler[kind][j-1];
					bind_arg[kind][j]     = bind_arg[kind][j-1];
				end
				bind_key[kind][pos]     = key;
				bind_ctx[kind][pos]     = context_mask;
				bind_handler[kind][pos] = handler_id;
				bind_arg[kind][pos]     = handler_arg;
				bind_fill[kind]++;
				ans.status = STATUS_OK;
			end
		end else begin
			if (kind >= KINDS) begin
				ans.status = STATUS_NOT_FOUND;
			end else begin
				live_mods = modifiers & ~mask_copy;
				hit = find_binding(kind, {code, live_mods}, context_mask);
				// exact code missed: retry once under the wildcard code
				if (hit < 0 && code != '0)
					hit = find_binding(kind, {CODE_W'(0), live_mods}, context_mask);
				if (hit < 0) begin
					ans.status = STATUS_NOT_FOUND;
				end else begin
					ans.status  = STATUS_OK;
					ans.handler = bind_handler[kind][hit];
					ans.arg     = bind_arg[kind][hit];
					ans.ctx     = bind_ctx[kind][hit];
				end
			end
		end
		expected_answers.push_back(ans);
	endtask

	// monitor all three channels; results are popped before new commands
	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (bind_fill[k])
				bind_fill[k] = 0;
			mask_copy = IGNORE_MASK_RESET;
			expected_answers.delete();
			fail_tally = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mask_copy = cfg_data;
			if (out_valid && !out_stall) begin
				got_answer = {status, found_handler, found_arg, found_context};
				if (expected_answers.size() == 0) begin
					$display("%0t: result with no command owed: status %0d handler %h arg %h context %h",
						$time, status, found_handler, found_arg, found_context);
					fail_tally++;
				end else begin
					want_answer = expected_answers.pop_front();
					if (got_answer !== want_answer) begin
						$display("%0t: result mismatch: expected status %0d handler %h arg %h context %h",
							$time, want_answer.status, want_answer.handler, want_answer.arg,
							want_answer.ctx);
						$display("%0t:                  got status %0d handler %h arg %h context %h",
							$time, got_answer.status, got_answer.handler, got_answer.arg,
							got_answer.ctx);
						fail_tally++;
					end
				end
			end
			if (in_valid && !in_stall)
				resolve_command();
		end
		answers_due <= expected_answers.size();
		errors      <= fail_tally;
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sorted binding table lookup. A directed set
// of inserts and lookups covers the edge cases, then random phases under
// different ignore masks and idling patterns exercise the tables until they
// fill up. Results are checked by sbtl_checker.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbtl_pkg::*;

	localparam int ITEMS_PER_PHASE = 262;
	localparam int HOLD_CYCLES     = 400;
	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 2 * ENTRIES + 16;

	typedef struct {
		logic                 command;
		logic [KIND_IN_W-1:0] kind;
		logic [CODE_W-1:0]    code;
		logic [MODS_W-1:0]    mods;
		logic [CTX_W-1:0]     ctx;
		logic [HANDLER_W-1:0] hid;
		logic [ARG_W-1:0]     arg;
	} cmd_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 command      = CMD_INSERT;
	logic [KIND_IN_W-1:0] event_kind   = '0;
	logic [CODE_W-1:0]    code         = '0;
	logic [MODS_W-1:0]    modifiers    = '0;
	logic [CTX_W-1:0]     context_mask = '0;
	logic [HANDLER_W-1:0] handler_id   = '0;
	logic [ARG_W-1:0]     handler_arg  = '0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [MODS_W-1:0]    cfg_data     = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [HANDLER_W-1:0] found_handler;
	logic [ARG_W-1:0]     found_arg;
	logic [CTX_W-1:0]     found_context;

	int                check_errors;
	int                answers_due;
	int                idle_pct  = 0;
	int                stall_pct = 0;
	logic              hold_go   = 1'b0;
	logic              hold_seen = 1'b0;
	int                hold_left = 0;
	int                quiet     = 0;
	logic [MODS_W-1:0] mask_now  = IGNORE_MASK_RESET;
	cmd_t              placed_bindings[$];

	always #10 clk = ~clk;

	sorted_binding_table_lookup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.event_kind    (event_kind),
		.code          (code),
		.modifiers     (modifiers),
		.context_mask  (context_mask),
		.handler_id    (handler_id),
		.handler_arg   (handler_arg),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_handler (found_handler),
		.found_arg     (found_arg),
		.found_context (found_context)
	);

	sbtl_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.event_kind    (event_kind),
		.code          (code),
		.modifiers     (modifiers),
		.context_mask  (context_mask),
		.handler_id    (handler_id),
		.handler_arg   (handler_arg),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_handler (found_handler),
		.found_arg     (found_arg),
		.found_context (found_context),
		.errors        (check_errors),
		.answers_due   (answers_due)
	);

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: too long without any transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic cmd_t mk_command(logic cmd, logic [KIND_IN_W-1:0] kind,
		logic [CODE_W-1:0] cd, logic [MODS_W-1:0] mods, logic [CTX_W-1:0] ctx,
		logic [HANDLER_W-1:0] hid, logic [ARG_W-1:0] arg);
		cmd_t c;
		c.command = cmd;
		c.kind    = kind;
		c.code    = cd;
		c.mods    = mods;
		c.ctx     = ctx;
		c.hid     = hid;
		c.arg     = arg;
		return c;
	endfunction

	// random command; lookups mostly aim at bindings placed earlier
	task automatic pick_command(output cmd_t c);
		cmd_t seen;
		c.hid = HANDLER_W'($urandom);
		c.arg = $urandom;
		if ($urandom_range(9) == 0)
			c.kind = KIND_IN_W'($urandom_range(7, KINDS));
		else
			c.kind = KIND_IN_W'($urandom_range(KINDS - 1));
		if ($urandom_range(99) < 30) begin
			c.command = CMD_INSERT;
			case ($urandom_range(4))
				0: c.code = '0;
				4: c.code = CODE_W'($urandom);
				default: c.code = CODE_W'($urandom_range(1, 12));
			endcase
			if ($urandom_range(1) == 0)
				c.mods = MODS_W'($urandom_range(7));
			else
				c.mods = MODS_W'($urandom);
			case ($urandom_range(9))
				0: c.ctx = '0;
				1: c.ctx = '1;
				2, 3, 4: c.ctx = CTX_W'($urandom);
				default: c.ctx = CTX_W'(1) << $urandom_range(CTX_W - 1);
			endcase
			if (c.kind < KINDS)
				placed_bindings.push_back(c);
		end else begin
			c.command = CMD_LOOKUP;
			if (placed_bindings.size() != 0 && $urandom_range(3) != 0) begin
				seen = placed_bindings[$urandom_range(placed_bindings.size() - 1)];
				c.kind = seen.kind;
				// a foreign code forces the wildcard retry
				if ($urandom_range(3) == 0)
					c.code = CODE_W'($urandom_range(1, 255));
				else
					c.code = seen.code;
				if ($urandom_range(1) == 0)
					c.mods = seen.mods;
				else
					c.mods = seen.mods ^ (MODS_W'($urandom) & mask_now);
				case ($urandom_range(2))
					0: c.ctx = seen.ctx;
					1: c.ctx = CTX_W'(1) << $urandom_range(CTX_W - 1);
					default: c.ctx = CTX_W'($urandom);
				endcase
			end else begin
				if ($urandom_range(1) == 0)
					c.code = CODE_W'($urandom_range(12));
				else
					c.code = CODE_W'($urandom);
				c.mods = MODS_W'($urandom);
				c.ctx  = CTX_W'($urandom);
			end
		end
	endtask

	// present one command, idling first at random, and hold it until taken
	task automatic offer_command(input cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= c.command;
		event_kind   <= c.kind;
		code         <= c.code;
		modifiers    <= c.mods;
		context_mask <= c.ctx;
		handler_id   <= c.hid;
		handler_arg  <= c.arg;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (answers_due != 0);
	endtask

	// mask write only once every owed result has come back
	task automatic write_ignore_mask(input logic [MODS_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mask_now = value;
	endtask

	task automatic run_phase(input int sender_idle, input int recv_stall,
		input logic [MODS_W-1:0] mask, input bit with_pressure);
		cmd_t c;
		write_ignore_mask(mask);
		idle_pct = sender_idle;
		stall_pct <= recv_stall;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			// long receiver hold-off while commands keep coming
			if (with_pressure && n == 40)
				hold_go <= ~hold_go;
			// sender pause until everything has come back
			if (with_pressure && n == 150) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			pick_command(c);
			offer_command(c);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad kinds, field extremes, ordering and lookup cases
		offer_command(mk_command(CMD_INSERT, 3'd5, 8'd1, 16'h0000, 16'h0001, 16'h0001, 32'h1));
		offer_command(mk_command(CMD_INSERT, 3'd7, 8'd1, 16'h0000, 16'h0001, 16'h0001, 32'h1));
		offer_command(mk_command(CMD_INSERT, 3'd0, 8'hff, 16'hffff, 16'hffff, 16'hffff,
			32'hffffffff));
		offer_command(mk_command(CMD_INSERT, 3'd0, 8'd0, 16'h0000, 16'h0001, 16'h0001, 32'h0));
		offer_command(mk_command(CMD_INSERT, 3'd0, 8'd10, 16'h0004, 16'h0002, 16'h0002,
			32'h22222222));
		// equal key lands after the existing one
		offer_command(mk_command(CMD_INSERT, 3'd0, 8'd10, 16'h0004, 16'h0004, 16'h0003,
			32'h33333333));
		offer_command(mk_command(CMD_INSERT, 3'd0, 8'd10, 16'h0001, 16'h0006, 16'h0004,
			32'h44444444));
		offer_command(mk_command(CMD_INSERT, 3'd0, 8'd0, 16'h0004, 16'hffff, 16'h0005,
			32'h55555555));
		offer_command(mk_command(CMD_INSERT, 3'd4, 8'd1, 16'h0000, 16'h8000, 16'h0006,
			32'h66666666));
		// ignored bit makes the all-ones entry unreachable
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'hff, 16'hffff, 16'h8000, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'd10, 16'h0006, 16'h0004, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'd10, 16'h0004, 16'h0006, 16'h0, 32'h0));
		// miss on the code, hit on the wildcard retry
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'd10, 16'h0004, 16'h0008, 16'h0, 32'h0));
		// wildcard lookup makes one pass only
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'd0, 16'h0000, 16'h0002, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'd0, 16'h0002, 16'h0001, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd5, 8'd1, 16'h0000, 16'hffff, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd7, 8'd1, 16'h0000, 16'hffff, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd4, 8'd1, 16'h0000, 16'hffff, 16'h0, 32'h0));
		offer_command(mk_command(CMD_LOOKUP, 3'd3, 8'd1, 16'h0000, 16'hffff, 16'h0, 32'h0));
		// empty context never overlaps
		offer_command(mk_command(CMD_LOOKUP, 3'd0, 8'd200, 16'h0000, 16'h0000, 16'h0, 32'h0));
		in_valid <= 1'b0;

		// random phases under different masks and idling
		run_phase(0, 0, 16'h0000, 1'b1);
		run_phase(63, 0, 16'hffff, 1'b0);
		run_phase(0, 63, MODS_W'($urandom), 1'b0);
		run_phase(32, 32, IGNORE_MASK_RESET, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (check_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
